[design/pgrps_pkg.sv]
package pgrps_pkg;

  localparam int CLIENTS_DEF    = 4096;
  localparam int GAIN_FRAC_BITS = 15;
  localparam int RAMP_EXT       = (GAIN_FRAC_BITS > 15) ? (31 - GAIN_FRAC_BITS) : 16;
  localparam int GAIN_W         = 16;
  localparam int RAMP_W         = GAIN_W + RAMP_EXT;
  localparam int STEP_W         = RAMP_W + 1;
  localparam int SUM_W          = RAMP_W + 2;
  localparam int SAMPLE_W       = 16;
  localparam int CLIENT_W       = 12;
  localparam int FRAMES_W       = 13;
  localparam int CHANS_W        = 4;
  localparam int INDEX_W        = 3;
  localparam int MP_W           = SAMPLE_W + GAIN_W;
  localparam int PROD_W         = MP_W + RAMP_W;
  localparam int SHIFT_GAIN     = GAIN_FRAC_BITS + RAMP_EXT;
  localparam int SHIFT_PAN      = 2 * GAIN_FRAC_BITS + RAMP_EXT;
  localparam int DIV_STEPS      = STEP_W;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS + 1);

  localparam int IN_TDATA_W     = 104;
  localparam int OUT_TDATA_W    = 24;

  localparam logic [GAIN_W-1:0]   GAIN_ONE = GAIN_W'(1 << GAIN_FRAC_BITS);
  localparam logic [SAMPLE_W-1:0] SAT_POS  = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] SAT_NEG  = 16'h8000;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_STEP,
    ST_RAMP,
    ST_MUL,
    ST_EMIT
  } state_t;

endpackage

[design/pcm_gain_ramp_pan_saturate.sv]
// Channel  Direction  Handshake                     Payload
// s_axis   in         s_axis_tvalid/s_axis_tready   tdata: sample fields and header, tlast
// m_axis   out        m_axis_tvalid/m_axis_tready   tdata: sample_out, clipped, tlast
//
// One sample at a time. A sample inside a running ramp passes through accept, ramp, multiply and
// emit; a bypass sample through accept and emit. The first sample of a ramped buffer adds a gain
// table read, the step divide, one quotient bit per cycle, and the step update.
// After reset all CLIENTS entries of the gain table are cleared, one entry per cycle, with
// s_axis_tready low. A stalled m_axis holds the result and the emit step; the next sample
// may still be taken while the previous result waits.
module pcm_gain_ramp_pan_saturate #(
  parameter int CLIENTS = pgrps_pkg::CLIENTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // client_id, snapshot_valid, target_gain, pan_left, pan_right, frame_count,
  // channel_count, channel_index, sample_in, zero fill
  input  logic [pgrps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // sample_out, clipped, zero fill
  output logic [pgrps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                 m_axis_tlast
);
  import pgrps_pkg::*;

  localparam int AW = $clog2(CLIENTS);

  state_t state, state_next;

  logic [CLIENT_W-1:0] in_client;
  logic                in_snap;
  logic [GAIN_W-1:0]   in_target, in_pan_l, in_pan_r;
  logic [FRAMES_W-1:0] in_fc;
  logic [CHANS_W-1:0]  in_cc;
  logic [INDEX_W-1:0]  in_idx;
  logic [SAMPLE_W-1:0] in_sample;

  assign in_client = s_axis_tdata[11:0];
  assign in_snap   = s_axis_tdata[12];
  assign in_target = s_axis_tdata[28:13];
  assign in_pan_l  = s_axis_tdata[44:29];
  assign in_pan_r  = s_axis_tdata[60:45];
  assign in_fc     = s_axis_tdata[73:61];
  assign in_cc     = s_axis_tdata[77:74];
  assign in_idx    = s_axis_tdata[80:78];
  assign in_sample = s_axis_tdata[96:81];

  logic                in_buffer, bypass;
  logic [CLIENT_W-1:0] lat_client;
  logic [GAIN_W-1:0]   lat_target, lat_pan_l, lat_pan_r;
  logic [FRAMES_W-1:0] lat_fc;
  logic [CHANS_W-1:0]  lat_cc;
  logic [INDEX_W-1:0]  item_idx;
  logic                item_last;
  logic [SAMPLE_W-1:0] item_sample;

  logic [RAMP_W-1:0]   ramp_gain, ramp_lo, ramp_hi;
  logic [STEP_W-1:0]   ramp_step;
  logic [STEP_W-1:0]   div_q;
  logic [FRAMES_W-1:0] div_rem;
  logic                div_neg;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [MP_W-1:0]     mp;
  logic [PROD_W-1:0]   prod;
  logic                panned;
  logic [AW-1:0]       clr_addr;

  logic                out_valid, out_last;
  logic [SAMPLE_W-1:0] out_sample;
  logic                out_clip;

  logic in_fire, open_now, hdr_skip, open_ramp, open_unity, emit_ok;

  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr;
  logic [GAIN_W-1:0]   mem_wdata, mem_rdata;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign open_now      = in_fire && !in_buffer;
  assign hdr_skip      = (in_client == '0) || (32'(in_client) >= 32'(CLIENTS)) ||
                         (in_fc == '0) || (in_cc == '0);
  assign open_ramp     = open_now && !hdr_skip && in_snap;
  assign open_unity    = open_now && !hdr_skip && !in_snap;
  assign emit_ok       = (state == ST_EMIT) && (!out_valid || m_axis_tready);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (open_unity) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(in_client);
      mem_wdata = GAIN_ONE;
    end else if (emit_ok && item_last && !bypass) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(lat_client);
      mem_wdata = lat_target;
    end
  end

  assign mem_re = open_ramp;

  pgrps_ram #(
    .WIDTH (GAIN_W),
    .DEPTH (CLIENTS)
  ) u_gain_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (AW'(in_client)),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(CLIENTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (open_ramp) begin
            state_next = ST_READ;
          end else if (open_now || bypass) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_RAMP;
          end
        end
      end
      ST_READ: state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == '0) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: state_next = ST_RAMP;
      ST_RAMP: state_next = ST_MUL;
      ST_MUL:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_buffer <= 1'b0;
      bypass    <= 1'b0;
    end else begin
      if (open_now) begin
        in_buffer <= 1'b1;
        bypass    <= !open_ramp;
      end else if (emit_ok && item_last) begin
        in_buffer <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_idx    <= in_idx;
      item_last   <= s_axis_tlast;
      item_sample <= in_sample;
    end
    if (open_now) begin
      lat_client <= in_client;
      lat_target <= in_target;
      lat_pan_l  <= in_pan_l;
      lat_pan_r  <= in_pan_r;
      lat_fc     <= in_fc;
      lat_cc     <= in_cc;
    end
  end

  // ramp setup and step divide
  logic [RAMP_W-1:0]   start_g, target_g;
  logic [SUM_W-1:0]    diff;
  logic [STEP_W-1:0]   diff_mag;
  logic [FRAMES_W:0]   rem_sh;
  logic                rem_ge;

  assign start_g  = {mem_rdata, RAMP_EXT'(0)};
  assign target_g = {lat_target, RAMP_EXT'(0)};
  assign diff     = {2'b00, target_g} - {2'b00, start_g};
  assign diff_mag = diff[SUM_W-1] ? STEP_W'(-diff) : STEP_W'(diff);
  assign rem_sh   = {div_rem, div_q[STEP_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, lat_fc};

  // ramp advance and clamp, sample magnitude and pan factor
  logic signed [SUM_W-1:0] ramp_sum;
  logic                    samp_neg;
  logic [SAMPLE_W-1:0]     samp_mag;
  logic                    panned_now;
  logic [GAIN_W-1:0]       factor;

  assign ramp_sum   = $signed({2'b00, ramp_gain}) + $signed({ramp_step[STEP_W-1], ramp_step});
  assign samp_neg   = item_sample[SAMPLE_W-1];
  assign samp_mag   = samp_neg ? (~item_sample + 1'b1) : item_sample;
  assign panned_now = (lat_cc >= CHANS_W'(2)) && (item_idx < INDEX_W'(2));
  assign factor     = !panned_now ? GAIN_W'(1) :
                      (item_idx == '0) ? lat_pan_l : lat_pan_r;

  always_ff @(posedge clk) begin
    case (state)
      ST_READ: begin
        ramp_gain <= start_g;
        ramp_lo   <= (start_g < target_g) ? start_g : target_g;
        ramp_hi   <= (start_g < target_g) ? target_g : start_g;
        div_neg   <= diff[SUM_W-1];
        div_q     <= diff_mag;
        div_rem   <= '0;
        div_cnt   <= DIV_CNT_W'(DIV_STEPS);
      end
      ST_DIV: begin
        if (div_cnt != '0) begin
          div_rem <= rem_ge ? FRAMES_W'(rem_sh - {1'b0, lat_fc}) : rem_sh[FRAMES_W-1:0];
          div_q   <= {div_q[STEP_W-2:0], rem_ge};
          div_cnt <= div_cnt - 1'b1;
        end
      end
      ST_STEP: begin
        ramp_step <= div_neg ? (~div_q + 1'b1) : div_q;
      end
      ST_RAMP: begin
        if (item_idx == '0) begin
          if (ramp_sum < $signed({2'b00, ramp_lo})) begin
            ramp_gain <= ramp_lo;
          end else if (ramp_sum > $signed({2'b00, ramp_hi})) begin
            ramp_gain <= ramp_hi;
          end else begin
            ramp_gain <= ramp_sum[RAMP_W-1:0];
          end
        end
        mp     <= MP_W'(samp_mag) * MP_W'(factor);
        panned <= panned_now;
      end
      ST_MUL: begin
        prod <= PROD_W'(mp) * PROD_W'(ramp_gain);
      end
      default: begin
      end
    endcase
  end

  // truncate and saturate
  logic [PROD_W-1:0]   shifted;
  logic [SAMPLE_W-1:0] res;
  logic                clip;

  always_comb begin
    shifted = panned ? (prod >> SHIFT_PAN) : (prod >> SHIFT_GAIN);
    res     = item_sample;
    clip    = 1'b0;
    if (!bypass) begin
      if (!samp_neg) begin
        if (shifted > PROD_W'(SAT_POS)) begin
          res  = SAT_POS;
          clip = 1'b1;
        end else begin
          res = shifted[SAMPLE_W-1:0];
        end
      end else begin
        if (shifted > PROD_W'(SAT_NEG)) begin
          res  = SAT_NEG;
          clip = 1'b1;
        end else begin
          res = ~shifted[SAMPLE_W-1:0] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_ok) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ok) begin
      out_sample <= res;
      out_clip   <= clip;
      out_last   <= item_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {7'b0, out_clip, out_sample};

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_fire)
    else $error("transfer accepted during table clear");

  a_one_mem_access: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("gain table read and write in one cycle");

  a_fire_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state != ST_IDLE))
    else $error("sequencer stayed idle after a transfer");

  a_ramp_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL && !bypass) |-> (ramp_gain >= ramp_lo && ramp_gain <= ramp_hi))
    else $error("ramp gain outside its start and target");

  a_mul_after_ramp: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> ($past(state) == ST_RAMP))
    else $error("multiply without ramp update");

endmodule

[design/pgrps_ram.sv]
module pgrps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[tb/pcm_gain_ramp_pan_saturate_tb.sv]
`timescale 1ns / 100ps

module pcm_gain_ramp_pan_saturate_tb;
  import pgrps_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int ITEM_TARGET = 700;

  typedef struct packed {
    logic [15:0] pcm;
    logic [2:0]  chan_idx;
    logic [3:0]  chan_cnt;
    logic [12:0] frames;
    logic [15:0] pan_r;
    logic [15:0] pan_l;
    logic [15:0] target;
    logic        snap_ok;
    logic [11:0] client;
  } pcm_item_t;

  localparam int ITEM_W = $bits(pcm_item_t);

  typedef struct packed {
    logic [15:0] pcm;
    logic        clip;
    logic        last;
  } pcm_result_t;

  class gain_scoreboard;
    logic [15:0] stored_gain [CLIENTS_DEF];
    pcm_item_t   hdr;
    bit          open;
    bit          passthru;
    longint      ramp_acc;
    longint      ramp_inc;
    longint      ramp_floor;
    longint      ramp_ceil;
    pcm_result_t expected_q[$];
    int          errors;

    function new();
      foreach (stored_gain[i]) stored_gain[i] = '0;
      hdr = '0;
      open = 0;
      passthru = 0;
      ramp_acc = 0;
      ramp_inc = 0;
      ramp_floor = 0;
      ramp_ceil = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_sample(pcm_item_t it, bit last);
      longint      start;
      longint      goal;
      bit          panned;
      bit          neg;
      int          sv;
      bit [63:0]   prod;
      logic [15:0] pan;
      pcm_result_t r;
      if (!open) begin
        hdr = it;
        open = 1;
        if (hdr.client == 0 || int'(hdr.client) >= CLIENTS_DEF || hdr.frames == 0 ||
            hdr.chan_cnt == 0) begin
          passthru = 1;
        end else if (!hdr.snap_ok) begin
          stored_gain[hdr.client] = GAIN_ONE;
          passthru = 1;
        end else begin
          passthru = 0;
          start = longint'(stored_gain[hdr.client]) * (longint'(1) << RAMP_EXT);
          goal = longint'(hdr.target) * (longint'(1) << RAMP_EXT);
          ramp_acc = start;
          ramp_inc = (goal - start) / longint'(hdr.frames);
          ramp_floor = (start < goal) ? start : goal;
          ramp_ceil = (start < goal) ? goal : start;
        end
      end
      r.pcm = it.pcm;
      r.clip = 1'b0;
      r.last = last;
      if (!passthru) begin
        if (it.chan_idx == 0) begin
          ramp_acc += ramp_inc;
          if (ramp_acc < ramp_floor) ramp_acc = ramp_floor;
          if (ramp_acc > ramp_ceil) ramp_acc = ramp_ceil;
        end
        panned = hdr.chan_cnt >= 2 && it.chan_idx < 2;
        pan = (it.chan_idx == 0) ? hdr.pan_l : hdr.pan_r;
        sv = $signed(it.pcm);
        neg = sv < 0;
        prod = $unsigned(64'(neg ? -sv : sv)) * $unsigned(ramp_acc);
        if (panned) prod = (prod * {48'b0, pan}) >> SHIFT_PAN;
        else prod = prod >> SHIFT_GAIN;
        if (!neg) begin
          if (prod > 64'd32767) begin
            r.pcm = SAT_POS;
            r.clip = 1'b1;
          end else begin
            r.pcm = prod[15:0];
          end
        end else begin
          if (prod > 64'd32768) begin
            r.pcm = SAT_NEG;
            r.clip = 1'b1;
          end else begin
            r.pcm = ~prod[15:0] + 16'd1;
          end
        end
      end
      if (last) begin
        if (!passthru) stored_gain[hdr.client] = hdr.target;
        open = 0;
      end
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("%0t ERROR %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [15:0] pcm, logic clip, logic last);
      pcm_result_t exp_r;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected transfer: sample %h clipped %b last %b", pcm, clip, last));
      end else begin
        exp_r = expected_q.pop_front();
        if (pcm !== exp_r.pcm)
          report($sformatf("sample_out %h, expected %h", pcm, exp_r.pcm));
        if (clip !== exp_r.clip)
          report($sformatf("clipped %b, expected %b (sample %h)", clip, exp_r.clip, exp_r.pcm));
        if (last !== exp_r.last)
          report($sformatf("last %b, expected %b (sample %h)", last, exp_r.last, exp_r.pcm));
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  gain_scoreboard sb;
  int items_sent = 0;
  int burst_left = 0;
  bit tx_gapless = 0;
  int idle_cycles = 0;
  int rx_mode = 0;
  int rx_phase = 0;
  int rx_hold = 0;

  pcm_gain_ramp_pan_saturate DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_sample(pcm_item_t'(s_axis_tdata[ITEM_W-1:0]), s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata[15:0], m_axis_tdata[16], m_axis_tlast);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rx_phase == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_phase <= $urandom_range(50, 300);
    end else begin
      rx_phase <= rx_phase - 1;
    end
    case (rx_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= ($urandom_range(0, 9) < 7);
      end
      default: begin
        if (rx_hold > 0) begin
          rx_hold <= rx_hold - 1;
          m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          rx_hold <= $urandom_range(1, 30);
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    endcase
  end

  task automatic push_sample(input pcm_item_t it, input logic last);
    int gap;
    if (burst_left <= 0) begin
      gap = tx_gapless ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
      tx_gapless = ($urandom_range(0, 3) == 0);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_TDATA_W'(it);
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic pcm_item_t make_hdr(int client, bit snap, int target, int pl, int pr,
                                         int frames, int chans);
    pcm_item_t h;
    h = '0;
    h.client = 12'(client);
    h.snap_ok = snap;
    h.target = 16'(target);
    h.pan_l = 16'(pl);
    h.pan_r = 16'(pr);
    h.frames = 13'(frames);
    h.chan_cnt = 4'(chans);
    return h;
  endfunction

  task automatic run_buffer(input pcm_item_t hdr, input int nframes, input int nchans,
                            input bit extremes, input bit scramble);
    pcm_item_t it;
    int k;
    k = 0;
    for (int f = 0; f < nframes; f++) begin
      for (int c = 0; c < nchans; c++) begin
        it = hdr;
        if (scramble && k != 0) begin
          it.client = 12'($urandom);
          it.snap_ok = 1'($urandom);
          it.target = 16'($urandom);
          it.pan_l = 16'($urandom);
          it.pan_r = 16'($urandom);
          it.frames = 13'($urandom_range(0, 4096));
          it.chan_cnt = 4'($urandom_range(0, 8));
        end
        it.chan_idx = 3'(c);
        if (extremes || $urandom_range(0, 3) == 0) begin
          case (k % 4)
            0: it.pcm = 16'h7fff;
            1: it.pcm = 16'h8000;
            2: it.pcm = 16'h0000;
            default: it.pcm = 16'hffff;
          endcase
        end else begin
          it.pcm = 16'($urandom);
        end
        push_sample(it, f == nframes - 1 && c == nchans - 1);
        k++;
      end
    end
  endtask

  function automatic int pick_gain();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return 32768;
    if (r == 2) return $urandom_range(32769, 65535);
    return $urandom_range(0, 32768);
  endfunction

  initial begin
    pcm_item_t hdr;
    int r, client, frames, chans, nframes, nchans;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    run_buffer(make_hdr(0, 1, 16384, 32768, 32768, 1, 2), 1, 2, 1, 0);
    run_buffer(make_hdr(5, 1, 16384, 32768, 32768, 0, 2), 1, 1, 1, 0);
    run_buffer(make_hdr(6, 1, 16384, 32768, 32768, 2, 0), 1, 1, 1, 0);
    run_buffer(make_hdr(3, 0, 100, 200, 300, 4, 2), 1, 1, 1, 0);
    run_buffer(make_hdr(3, 1, 32768, 32768, 16384, 2, 2), 2, 2, 1, 0);
    run_buffer(make_hdr(3, 1, 0, 32768, 32768, 1, 1), 1, 1, 1, 0);
    run_buffer(make_hdr(7, 1, 32768, 24576, 8192, 1, 3), 2, 3, 1, 1);
    run_buffer(make_hdr(9, 1, 65535, 65535, 65535, 1, 2), 1, 2, 1, 0);
    run_buffer(make_hdr(4095, 1, 1, 0, 32768, 4096, 8), 1, 4, 1, 0);
    hold_until_drained();

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 19) == 0) hold_until_drained();
      r = $urandom_range(0, 9);
      if (r == 0) client = 0;
      else if (r <= 2) client = $urandom_range(1, 4095);
      else client = $urandom_range(1, 7);
      r = $urandom_range(0, 19);
      if (r == 0) frames = 0;
      else if (r == 1) frames = 4096;
      else if (r <= 3) frames = $urandom_range(7, 300);
      else frames = $urandom_range(1, 6);
      r = $urandom_range(0, 9);
      if (r == 0) chans = 0;
      else if (r <= 3) chans = 1;
      else if (r <= 6) chans = 2;
      else chans = $urandom_range(3, 8);
      hdr = make_hdr(client, $urandom_range(0, 19) != 0, pick_gain(), pick_gain(),
                     pick_gain(), frames, chans);
      nchans = (chans == 0) ? $urandom_range(1, 2) : chans;
      nframes = (frames == 0) ? 1 : ((frames > 6) ? $urandom_range(1, 4) : frames);
      r = $urandom_range(0, 9);
      if (r == 0) nframes += $urandom_range(1, 2);
      else if (r == 1) nframes = $urandom_range(1, nframes);
      else if (r == 2) nchans = $urandom_range(1, 8);
      run_buffer(hdr, nframes, nchans, 0, $urandom_range(0, 4) == 0);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
